@@ rtl/core/sliding_window_argmax_assert.svh @@
// Assertion macros for the sliding window argmax block.
// Each macro checks on the rising clock edge and is disabled while reset is low.
`ifndef SLIDING_WINDOW_ARGMAX_ASSERT_SVH
`define SLIDING_WINDOW_ARGMAX_ASSERT_SVH
`ifndef ASSERT_OFF
`define SWA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SWA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SWA_ASSERT(lbl, clk, rstn, prop, msg)
`define SWA_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ rtl/core/swa_pkg.sv @@
`default_nettype none

package swa_pkg;

  // Default sizes of the window store and of one sample.
  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // Field widths fixed by the register map and the result word.
  localparam int unsigned COUNT_BITS    = 7;
  localparam int unsigned RESULT_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS  = 8;
  localparam int unsigned CFG_DATA_BITS = 32;

  // The series count saturates here.
  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = 7'd127;

  // Register reset values.
  localparam logic [COUNT_BITS-1:0] WINDOW_LENGTH_RST = 7'd64;
  localparam logic [COUNT_BITS-1:0] LEAST_COUNT_RST   = 7'd1;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARTIAL_MODE  = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEAST_COUNT   = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILL_VALUE    = 8'd3;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [COUNT_BITS-1:0]         window_length;
    logic                          partial_mode;
    logic [COUNT_BITS-1:0]         least_count;
    logic signed [RESULT_BITS-1:0] fill_value;
  } cfg_t;

  // Sequencer states.
  typedef enum logic {
    SWA_IDLE,
    SWA_SCAN
  } swa_state_e;

endpackage

`default_nettype wire

@@ rtl/core/swa_if.sv @@
`default_nettype none

// Sample channel.
interface swa_in_if #(
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          series_start;

  modport source (output valid, output sample, output series_start, input ready);
  modport sink (input valid, input sample, input series_start, output ready);
endinterface

// Result channel.
interface swa_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [swa_pkg::RESULT_BITS-1:0] answer;
  logic                                   filled;

  modport source (output valid, output answer, output filled, input ready);
  modport sink (input valid, input answer, input filled, output ready);
endinterface

// Register write channel.
interface swa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [swa_pkg::CFG_IDX_BITS-1:0]  reg_index;
  logic [swa_pkg::CFG_DATA_BITS-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/swa_cfg.sv @@
`default_nettype none

module swa_cfg (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  swa_cfg_if.sink      cfg_i,
  output swa_pkg::cfg_t cfg_o
);

  swa_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register file; indexes beyond the map are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length <= swa_pkg::WINDOW_LENGTH_RST;
      cfg_q.partial_mode  <= 1'b0;
      cfg_q.least_count   <= swa_pkg::LEAST_COUNT_RST;
      cfg_q.fill_value    <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        swa_pkg::CFG_WINDOW_LENGTH: begin
          cfg_q.window_length <= cfg_i.wdata[swa_pkg::COUNT_BITS-1:0];
        end
        swa_pkg::CFG_PARTIAL_MODE: begin
          cfg_q.partial_mode <= cfg_i.wdata[0];
        end
        swa_pkg::CFG_LEAST_COUNT: begin
          cfg_q.least_count <= cfg_i.wdata[swa_pkg::COUNT_BITS-1:0];
        end
        swa_pkg::CFG_FILL_VALUE: begin
          cfg_q.fill_value <= $signed(cfg_i.wdata[swa_pkg::RESULT_BITS-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/swa_cell.sv @@
`default_nettype none

module swa_cell #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned CELL_IDX    = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  shift_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_i,
  output logic signed [SAMPLE_BITS-1:0]              sample_o,
  input  wire logic [swa_pkg::COUNT_BITS-1:0]        n_i,
  input  wire logic                                  tok_have_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         tok_key_i,
  input  wire logic [$clog2(MAX_WINDOW)-1:0]         tok_age_i,
  output logic                                       tok_have_o,
  output logic signed [SAMPLE_BITS-1:0]              tok_key_o,
  output logic [$clog2(MAX_WINDOW)-1:0]              tok_age_o
);

  localparam int unsigned AGE_BITS = $clog2(MAX_WINDOW);

  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic                          tok_have_q, tok_have_d;
  logic signed [SAMPLE_BITS-1:0] tok_key_q, tok_key_d;
  logic [AGE_BITS-1:0]           tok_age_q, tok_age_d;
  logic                          active;
  logic                          take;

  // Sample slot: shifts toward older positions when a word is accepted.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      smp_q <= sample_i;
    end
  end

  // This cell lies inside the current window.
  assign active = (32'(n_i) > CELL_IDX);

  // Strictly greater replaces the best, so ties stay with the newer sample.
  assign take       = active && (!tok_have_i || (smp_q > tok_key_i));
  assign tok_have_d = tok_have_i || active;
  assign tok_key_d  = take ? smp_q : tok_key_i;
  assign tok_age_d  = take ? AGE_BITS'(CELL_IDX) : tok_age_i;

  // The running best is handed to the next older cell every cycle.
  always_ff @(posedge clk_i) begin
    tok_have_q <= tok_have_d;
    tok_key_q  <= tok_key_d;
    tok_age_q  <= tok_age_d;
  end

  assign sample_o   = smp_q;
  assign tok_have_o = tok_have_q;
  assign tok_key_o  = tok_key_q;
  assign tok_age_o  = tok_age_q;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_argmax.sv @@
// Sliding window argmax.
// smp_i carries one signed sample and a series start flag per word; res_o
// returns one word per sample: the position of the window maximum (0 is the
// oldest sample in the window, ties go to the newest) with filled low, or the
// fill value with filled high when a partial window gives no position.
// cfg_i writes the four registers; it is always ready. The user must see that it
// is written only while no sample is in flight; the block does not enforce it.
// Samples sit in a row of MAX_WINDOW cells, newest first. A best-so-far token
// walks from the newest cell to the oldest one cell per cycle. A new sample is
// taken only after the walk of the previous one has ended and its result has
// been captured into the output register.
// The result sits in an output register; the next sample is accepted while it
// waits. A stalled receiver holds the result, and a finished walk waits for
// the register to free up before the next sample is taken.
// Reset clears the series count and the registers to their defaults; the
// sample cells are not cleared, since only cells of the current series are
// ever searched.
`default_nettype none
`include "sliding_window_argmax_assert.svh"

module sliding_window_argmax #(
  parameter int unsigned MAX_WINDOW  = swa_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  swa_in_if.sink    smp_i,
  swa_out_if.source res_o,
  swa_cfg_if.sink   cfg_i
);

  localparam int unsigned AGE_BITS = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_BITS = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CB       = swa_pkg::COUNT_BITS;
  localparam int unsigned RB       = swa_pkg::RESULT_BITS;

  swa_pkg::cfg_t      cfg;
  swa_pkg::swa_state_e state_q, state_d;

  logic [CB-1:0]       seen_q, cnt_base, cnt_new;
  logic [CB-1:0]       w_eff, n_d, n_q;
  logic                give_d, give_q;
  logic [CNT_BITS-1:0] scan_cnt_q;
  logic                accept, done, out_free, capture, in_ready;

  logic                   out_valid_q;
  logic signed [RB-1:0]   answer_q;
  logic                   filled_q;

  logic signed [SAMPLE_BITS-1:0] smp_w  [MAX_WINDOW+1];
  logic                          have_w [MAX_WINDOW+1];
  logic signed [SAMPLE_BITS-1:0] key_w  [MAX_WINDOW+1];
  logic [AGE_BITS-1:0]           age_w  [MAX_WINDOW+1];

  // Register file.
  swa_cfg u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_i),
    .cfg_o (cfg)
  );

  assign accept   = smp_i.valid && in_ready;
  assign done     = (32'(scan_cnt_q) == MAX_WINDOW);
  assign out_free = !out_valid_q || res_o.ready;

  // Series count including the new sample, saturating.
  assign cnt_base = smp_i.series_start ? '0 : seen_q;
  assign cnt_new  = (cnt_base < swa_pkg::COUNT_LIMIT) ? cnt_base + CB'(1) : cnt_base;

  // Effective window length and the span to search.
  always_comb begin
    if (cfg.window_length == '0) begin
      w_eff = CB'(1);
    end else if (32'(cfg.window_length) > MAX_WINDOW) begin
      w_eff = CB'(MAX_WINDOW);
    end else begin
      w_eff = cfg.window_length;
    end
    if (cnt_new >= w_eff) begin
      n_d    = w_eff;
      give_d = 1'b1;
    end else begin
      n_d    = cnt_new;
      give_d = cfg.partial_mode && (cnt_new >= cfg.least_count);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      swa_pkg::SWA_IDLE: begin
        if (smp_i.valid) begin
          state_d = swa_pkg::SWA_SCAN;
        end
      end
      swa_pkg::SWA_SCAN: begin
        if (done && out_free) begin
          state_d = swa_pkg::SWA_IDLE;
        end
      end
      default: begin
        state_d = swa_pkg::SWA_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    case (state_q)
      swa_pkg::SWA_IDLE: begin
        in_ready = 1'b1;
      end
      swa_pkg::SWA_SCAN: begin
        capture = done && out_free;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= swa_pkg::SWA_IDLE;
      seen_q     <= '0;
      n_q        <= '0;
      give_q     <= 1'b0;
      scan_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        seen_q     <= cnt_new;
        n_q        <= n_d;
        give_q     <= give_d;
        scan_cnt_q <= '0;
      end else if ((state_q == swa_pkg::SWA_SCAN) && !done) begin
        scan_cnt_q <= scan_cnt_q + CNT_BITS'(1);
      end
    end
  end

  // Head of the cell row: new sample and an empty token.
  assign smp_w[0]  = smp_i.sample;
  assign have_w[0] = 1'b0;
  assign key_w[0]  = '0;
  assign age_w[0]  = '0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swa_cell #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (accept),
      .sample_i  (smp_w[i]),
      .sample_o  (smp_w[i+1]),
      .n_i       (n_q),
      .tok_have_i(have_w[i]),
      .tok_key_i (key_w[i]),
      .tok_age_i (age_w[i]),
      .tok_have_o(have_w[i+1]),
      .tok_key_o (key_w[i+1]),
      .tok_age_o (age_w[i+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (capture) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Position counts from the oldest sample: n - 1 - age.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      if (give_q) begin
        answer_q <= $signed(RB'(n_q) - RB'(1) - RB'(age_w[MAX_WINDOW]));
        filled_q <= 1'b0;
      end else begin
        answer_q <= cfg.fill_value;
        filled_q <= 1'b1;
      end
    end
  end

  assign smp_i.ready  = in_ready;
  assign res_o.valid  = out_valid_q;
  assign res_o.answer = answer_q;
  assign res_o.filled = filled_q;

  // An accepted sample starts a fresh walk.
  `SWA_ASSERT_NEXT(a_accept_starts_scan, clk_i, rst_ni, accept, (state_q == swa_pkg::SWA_SCAN) && (scan_cnt_q == '0), "accept did not start a scan")
  // The walk counter never runs past the row.
  `SWA_ASSERT(a_scan_cnt_bound, clk_i, rst_ni, (state_q == swa_pkg::SWA_SCAN) |-> (32'(scan_cnt_q) <= MAX_WINDOW), "scan counter overran")
  // A searched window is never empty and never larger than the row.
  `SWA_ASSERT(a_span_bound, clk_i, rst_ni, ((state_q == swa_pkg::SWA_SCAN) && give_q) |-> ((n_q != '0) && (32'(n_q) <= MAX_WINDOW)), "window span out of range")
  // A result appears only at the end of a walk.
  `SWA_ASSERT(a_result_after_scan, clk_i, rst_ni, $rose(out_valid_q) |-> ($past(state_q) == swa_pkg::SWA_SCAN), "result without a scan")

endmodule

`default_nettype wire
